// File: hw/rtl/sequence_keyed_ring_cache_core_assert.svh
// ----------------------------------------------------------------------------
// sequence keyed ring cache assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_KEYED_RING_CACHE_CORE_ASSERT_SVH
`define SEQUENCE_KEYED_RING_CACHE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// consequent checked in the same cycle
`define SKRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent checked in the next cycle
`define SKRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SKRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/skrc_pkg.sv
// ----------------------------------------------------------------------------
// skrc_pkg
// shared types and codes of the sequence keyed ring cache
// ----------------------------------------------------------------------------
package skrc_pkg;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 9;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // command codes
    localparam cmd_t CMD_PUSH       = 3'd0;
    localparam cmd_t CMD_LOOKUP     = 3'd1;
    localparam cmd_t CMD_NEWEST     = 3'd2;
    localparam cmd_t CMD_NEWEST_KEY = 3'd3;
    localparam cmd_t CMD_OLDEST     = 3'd4;
    localparam cmd_t CMD_POP        = 3'd5;
    localparam cmd_t CMD_CLEAR      = 3'd6;

    // status codes
    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_NODATA = 3'd1;
    localparam status_t ST_SMALL  = 3'd2;
    localparam status_t ST_LARGE  = 3'd3;
    localparam status_t ST_ORDER  = 3'd4;
    localparam status_t ST_FULL   = 3'd5;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic                key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // ring controls from the sequencer
    typedef struct packed {
        logic rotate;
        logic write;
    } ring_ctrl_t;

endpackage

// File: hw/rtl/skrc_if.sv
// ----------------------------------------------------------------------------
// skrc channel interfaces
// command and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface skrc_cmd_if
    import skrc_pkg::*;
();
    logic                valid;
    logic                ready;
    cmd_t                command;
    logic [SEQ_W-1:0]    seq_number;
    logic                key_flag_in;
    logic [HANDLE_W-1:0] block_handle;

    modport source (output valid, output command, output seq_number,
                    output key_flag_in, output block_handle, input ready);
    modport sink   (input valid, input command, input seq_number,
                    input key_flag_in, input block_handle, output ready);
endinterface

interface skrc_rsp_if
    import skrc_pkg::*;
();
    logic                valid;
    logic                ready;
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SEQ_W-1:0]    seq_out;
    logic                key_flag_out;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output handle_out, output seq_out,
                    output key_flag_out, output occupancy, input ready);
    modport sink   (input valid, input status, input handle_out, input seq_out,
                    input key_flag_out, input occupancy, output ready);
endinterface

// File: hw/rtl/sequence_keyed_ring_cache_core.sv
// ----------------------------------------------------------------------------
// sequence_keyed_ring_cache_core
// first-in first-out cache of sequence-numbered entries with lookup commands
// ----------------------------------------------------------------------------
// The store holds up to DEPTH entries in a ring of cells that keeps the oldest
// entry in cell 0 outside a scan, with a copy of the newest entry in a
// register. One command word is taken at a time and answered by exactly one
// response word. Push, newest, oldest, pop, clear, the unused code, any read
// of an empty store and any lookup that misses the stored range go from the
// execute state straight to delivery, which registers the response word; the
// next command word is taken once the sequencer is back in idle. A lookup
// inside the stored range and the newest-key search of a non-empty store
// first pass through the scan state, which rotates the ring once round, one
// cell a cycle. A finished response waits in the output register while the
// next command word is accepted; if that register is still held when the
// next result is ready, the sequencer waits in delivery and the command side
// stalls until the response is taken.
`include "sequence_keyed_ring_cache_core_assert.svh"

module sequence_keyed_ring_cache_core
    import skrc_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    skrc_cmd_if.sink   cmd,
    skrc_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_SCAN    = 2'd2;
    localparam logic [1:0] S_DELIVER = 2'd3;

    // control state
    logic [1:0]          state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // latched command word
    cmd_t                cmd_code_reg,   cmd_code_next;
    logic [SEQ_W-1:0]    cmd_seq_reg,    cmd_seq_next;
    logic                cmd_key_reg,    cmd_key_next;
    logic [HANDLE_W-1:0] cmd_handle_reg, cmd_handle_next;

    // newest entry copy, scan position and pending result
    entry_t              newest_reg,     newest_next;
    logic [IDX_W-1:0]    scan_idx_reg,   scan_idx_next;
    status_t             res_status_reg, res_status_next;
    logic                res_found_reg,  res_found_next;
    entry_t              res_entry_reg,  res_entry_next;

    // response register
    status_t             rsp_status_reg, rsp_status_next;
    logic [HANDLE_W-1:0] rsp_handle_reg, rsp_handle_next;
    logic [SEQ_W-1:0]    rsp_seq_reg,    rsp_seq_next;
    logic                rsp_key_reg,    rsp_key_next;
    logic [OCC_W-1:0]    rsp_occ_reg,    rsp_occ_next;

    ring_ctrl_t          ring_ctrl;
    entry_t              head_entry;
    entry_t              push_entry;
    logic                scan_live;
    logic                scan_hit;

    assign push_entry = '{seq: cmd_seq_reg, key: cmd_key_reg, handle: cmd_handle_reg};

    // ring of cells; pushes go to slot count, rotation moves each cell down one
    skrc_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk      (clk),
        .ctrl     (ring_ctrl),
        .wr_pos   (count_reg),
        .wr_entry (push_entry),
        .head     (head_entry)
    );

    // during a scan cell 0 holds entry number scan_idx
    assign scan_live = (CNT_W'(scan_idx_reg) < count_reg);
    assign scan_hit  = (cmd_code_reg == CMD_LOOKUP) ? (head_entry.seq == cmd_seq_reg)
                                                    : head_entry.key;

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        cmd_code_next   = cmd_code_reg;
        cmd_seq_next    = cmd_seq_reg;
        cmd_key_next    = cmd_key_reg;
        cmd_handle_next = cmd_handle_reg;
        newest_next     = newest_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_entry_next  = res_entry_reg;
        rsp_status_next = rsp_status_reg;
        rsp_handle_next = rsp_handle_reg;
        rsp_seq_next    = rsp_seq_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_occ_next    = rsp_occ_reg;
        ring_ctrl       = '0;

        // response word taken downstream
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_code_next   = cmd.command;
                    cmd_seq_next    = cmd.seq_number;
                    cmd_key_next    = cmd.key_flag_in;
                    cmd_handle_next = cmd.block_handle;
                    state_next      = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                state_next      = S_DELIVER;
                unique case (cmd_code_reg)
                    CMD_PUSH:
                    begin
                        // order check ahead of the full check
                        if (count_reg != '0 && cmd_seq_reg <= newest_reg.seq)
                        begin
                            res_status_next = ST_ORDER;
                        end
                        else if (count_reg == FULL_COUNT)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ring_ctrl.write = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            newest_next     = push_entry;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NODATA;
                        end
                        else if (cmd_seq_reg < head_entry.seq)
                        begin
                            res_status_next = ST_SMALL;
                        end
                        else if (cmd_seq_reg > newest_reg.seq)
                        begin
                            res_status_next = ST_LARGE;
                        end
                        else
                        begin
                            // numbers rise strictly, so at most one entry matches
                            res_status_next = ST_NODATA;
                            scan_idx_next   = '0;
                            state_next      = S_SCAN;
                        end
                    end
                    CMD_NEWEST:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NODATA;
                        end
                        else
                        begin
                            res_found_next = 1'b1;
                            res_entry_next = newest_reg;
                        end
                    end
                    CMD_NEWEST_KEY:
                    begin
                        res_status_next = ST_NODATA;
                        if (count_reg != '0)
                        begin
                            scan_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    CMD_OLDEST:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NODATA;
                        end
                        else
                        begin
                            res_found_next = 1'b1;
                            res_entry_next = head_entry;
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_NODATA;
                        end
                        else
                        begin
                            res_found_next   = 1'b1;
                            res_entry_next   = head_entry;
                            ring_ctrl.rotate = 1'b1;
                            count_next       = count_reg - CNT_W'(1);
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        // unused code: nothing changes
                    end
                endcase
            end

            S_SCAN:
            begin
                // one full revolution brings the oldest entry back to cell 0;
                // a later key hit overrides an earlier one
                ring_ctrl.rotate = 1'b1;
                if (scan_live && scan_hit)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = 1'b1;
                    res_entry_next  = head_entry;
                end
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DELIVER;
                end
            end

            S_DELIVER:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_handle_next = res_found_reg ? res_entry_reg.handle : '0;
                    rsp_seq_next    = res_found_reg ? res_entry_reg.seq : '0;
                    rsp_key_next    = res_found_reg ? res_entry_reg.key : 1'b0;
                    rsp_occ_next    = OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_code_reg   <= cmd_code_next;
        cmd_seq_reg    <= cmd_seq_next;
        cmd_key_reg    <= cmd_key_next;
        cmd_handle_reg <= cmd_handle_next;
        newest_reg     <= newest_next;
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_entry_reg  <= res_entry_next;
        rsp_status_reg <= rsp_status_next;
        rsp_handle_reg <= rsp_handle_next;
        rsp_seq_reg    <= rsp_seq_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.handle_out   = rsp_handle_reg;
    assign rsp.seq_out      = rsp_seq_reg;
    assign rsp.key_flag_out = rsp_key_reg;
    assign rsp.occupancy    = rsp_occ_reg;

    // fill level never passes the ring size
    `SKRC_ASSERT_SAME(a_count_bound, clk, rst_n,
        1'b1, count_reg <= FULL_COUNT, "fill level above depth")
    // an accepted word is executed in the next cycle
    `SKRC_ASSERT_NEXT(a_accept_exec, clk, rst_n,
        state_reg == S_IDLE && cmd.valid, state_reg == S_EXEC, "accepted word not executed")
    // a scan stops after exactly one revolution
    `SKRC_ASSERT_NEXT(a_scan_end, clk, rst_n,
        state_reg == S_SCAN && scan_idx_reg == LAST_IDX, state_reg == S_DELIVER,
        "scan overran one revolution")
    // a pop from a non-empty store removes one entry
    `SKRC_ASSERT_NEXT(a_pop_count, clk, rst_n,
        state_reg == S_EXEC && cmd_code_reg == CMD_POP && count_reg != '0,
        count_reg == $past(count_reg) - CNT_W'(1), "pop did not drop fill level")
    // a finished result waits while the response register is blocked
    `SKRC_ASSERT_NEXT(a_result_held, clk, rst_n,
        state_reg == S_DELIVER && rsp_valid_reg && !rsp.ready,
        state_reg == S_DELIVER && rsp_valid_reg, "result lost while blocked")

endmodule

// File: hw/rtl/skrc_cell.sv
// ----------------------------------------------------------------------------
// skrc_cell
// one slot of the entry ring: takes its neighbour's entry or a pushed entry
// ----------------------------------------------------------------------------
module skrc_cell
    import skrc_pkg::*;
(
    input  logic       clk,
    input  ring_ctrl_t ctrl,
    input  logic       sel,
    input  entry_t     wr_entry,
    input  entry_t     nbr_entry,
    output entry_t     entry
);

    entry_t entry_reg;

    // rotation and push never coincide
    always_ff @(posedge clk)
    begin
        if (ctrl.rotate)
        begin
            entry_reg <= nbr_entry;
        end
        else if (ctrl.write && sel)
        begin
            entry_reg <= wr_entry;
        end
    end

    assign entry = entry_reg;

endmodule

// File: hw/rtl/skrc_ring.sv
// ----------------------------------------------------------------------------
// skrc_ring
// circular chain of entry cells, oldest entry held in cell 0
// ----------------------------------------------------------------------------
module skrc_ring
    import skrc_pkg::*;
#(
    parameter  int DEPTH = 256,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  ring_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] wr_pos,
    input  entry_t           wr_entry,
    output entry_t           head
);

    entry_t cell_q [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic sel;

        // push lands in the first free slot
        assign sel = (wr_pos == CNT_W'(gi));

        skrc_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .sel       (sel),
            .wr_entry  (wr_entry),
            .nbr_entry (cell_q[(gi + 1) % DEPTH]),
            .entry     (cell_q[gi])
        );
    end

    assign head = cell_q[0];

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sequence keyed ring cache core: a directed
// table, then phases of random command words checked against a mirror of
// the ring kept in the bench, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;

    import skrc_pkg::*;

    localparam int DEPTH        = 256;
    // a scan rotates the whole ring once, on top of the steps of a short command
    localparam int SCAN_CYCLES  = DEPTH + 3;
    localparam int RANDOM_WORDS = 1800;
    localparam int LIMIT_CYCLES = 2_000_000;
    // long receiver hold-off so that the command channel backs up
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_MAX   = 10;

    // code 7 has no meaning in the block, it must answer with plain success
    localparam cmd_t CMD_UNUSED = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_t;

    typedef struct packed {
        cmd_t                command;
        logic [SEQ_W-1:0]    seq;
        logic                key;
        logic [HANDLE_W-1:0] handle;
    } cache_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic                key;
        logic [OCC_W-1:0]    occ;
    } cache_result_t;

    typedef struct packed {
        cache_cmd_t    word;
        cache_result_t result;
    } table_row_t;

    logic clk;
    logic rst_n;

    skrc_cmd_if cmd_ch ();
    skrc_rsp_if rsp_ch ();

    sequence_keyed_ring_cache_core #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the ring as the block should hold it
    logic [SEQ_W-1:0]    ring_seq    [DEPTH];
    logic                ring_key    [DEPTH];
    logic [HANDLE_W-1:0] ring_handle [DEPTH];
    int unsigned         ring_head  = 0;
    int unsigned         ring_count = 0;

    // answers still owed by the block, oldest first
    cache_result_t pending_answers [$];
    table_row_t    directed_rows   [$];

    int  bad_words   = 0;
    int  rsp_words   = 0;
    int  cycle_count = 0;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // mirror of the ring
    // ------------------------------------------------------------------------
    function automatic int unsigned ring_slot(int unsigned pos);
        return (ring_head + pos) % DEPTH;
    endfunction

    // entry fields as they appear in a successful answer
    function automatic cache_result_t entry_answer(int unsigned slot);
        cache_result_t r;
        r        = '0;
        r.status = ST_OK;
        r.handle = ring_handle[slot];
        r.seq    = ring_seq[slot];
        r.key    = ring_key[slot];
        return r;
    endfunction

    // applies one command word to the mirror and returns the answer it owes
    function automatic cache_result_t cache_apply(cache_cmd_t w);
        cache_result_t r;
        int unsigned   slot;
        int            pos;
        r = '0;
        case (w.command)
            CMD_PUSH:
            begin
                // order check wins over the full check
                if (ring_count > 0 && w.seq <= ring_seq[ring_slot(ring_count - 1)])
                    r.status = ST_ORDER;
                else if (ring_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slot              = ring_slot(ring_count);
                    ring_seq[slot]    = w.seq;
                    ring_key[slot]    = w.key;
                    ring_handle[slot] = w.handle;
                    ring_count++;
                    r.status = ST_OK;
                end
            end
            CMD_LOOKUP:
            begin
                if (ring_count == 0)
                    r.status = ST_NODATA;
                else if (w.seq < ring_seq[ring_slot(0)])
                    r.status = ST_SMALL;
                else if (w.seq > ring_seq[ring_slot(ring_count - 1)])
                    r.status = ST_LARGE;
                else
                begin
                    // numbers rise strictly, so any search that hits is the same hit
                    r.status = ST_NODATA;
                    for (pos = 0; pos < int'(ring_count); pos++)
                        if (ring_seq[ring_slot(pos)] == w.seq)
                            r = entry_answer(ring_slot(pos));
                end
            end
            CMD_NEWEST:
            begin
                if (ring_count == 0)
                    r.status = ST_NODATA;
                else
                    r = entry_answer(ring_slot(ring_count - 1));
            end
            CMD_NEWEST_KEY:
            begin
                r.status = ST_NODATA;
                for (pos = int'(ring_count) - 1; pos >= 0; pos--)
                begin
                    if (ring_key[ring_slot(pos)] && r.status != ST_OK)
                        r = entry_answer(ring_slot(pos));
                end
            end
            CMD_OLDEST:
            begin
                if (ring_count == 0)
                    r.status = ST_NODATA;
                else
                    r = entry_answer(ring_slot(0));
            end
            CMD_POP:
            begin
                if (ring_count == 0)
                    r.status = ST_NODATA;
                else
                begin
                    r          = entry_answer(ring_slot(0));
                    ring_head  = ring_slot(1);
                    ring_count--;
                end
            end
            CMD_CLEAR:
            begin
                ring_count = 0;
                ring_head  = 0;
                r.status   = ST_OK;
            end
            default:
                r.status = ST_OK;
        endcase
        r.occ = ring_count[OCC_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random command words
    // ------------------------------------------------------------------------
    function automatic cache_cmd_t random_word(phase_mode_t mode, int key_pct);
        cache_cmd_t       w;
        int unsigned      roll;
        logic [SEQ_W-1:0] oldest;
        logic [SEQ_W-1:0] newest;
        w.seq    = $urandom;
        w.key    = $urandom_range(0, 1);
        w.handle = $urandom;
        oldest   = ring_seq[ring_slot(0)];
        newest   = ring_seq[ring_slot(ring_count - 1)];
        roll     = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                w.command = roll < 80 ? CMD_PUSH :
                            roll < 90 ? CMD_LOOKUP :
                            roll < 94 ? CMD_NEWEST_KEY :
                            roll < 97 ? CMD_OLDEST :
                            roll < 99 ? CMD_NEWEST : CMD_POP;
            MODE_DRAIN:
                w.command = roll < 15 ? CMD_PUSH :
                            roll < 42 ? CMD_POP :
                            roll < 66 ? CMD_LOOKUP :
                            roll < 76 ? CMD_NEWEST_KEY :
                            roll < 84 ? CMD_OLDEST :
                            roll < 92 ? CMD_NEWEST :
                            roll < 97 ? CMD_UNUSED : CMD_CLEAR;
            default:
                w.command = roll < 40 ? CMD_PUSH :
                            roll < 62 ? CMD_LOOKUP :
                            roll < 72 ? CMD_POP :
                            roll < 80 ? CMD_NEWEST_KEY :
                            roll < 87 ? CMD_NEWEST :
                            roll < 94 ? CMD_OLDEST :
                            roll < 99 ? CMD_UNUSED : CMD_CLEAR;
        endcase

        if (w.command == CMD_PUSH && ring_count > 0)
        begin
            w.key = ($urandom_range(0, 99) < key_pct);
            roll  = $urandom_range(0, 19);
            // mostly small steps, now and then a jump, and a few stale numbers
            if (roll < 2)
                w.seq = newest - $urandom_range(0, 5);
            else if (roll < 4)
                w.seq = newest + $urandom_range(4, 1000);
            else
                w.seq = newest + $urandom_range(1, 3);
        end
        else if (w.command == CMD_PUSH)
            w.key = ($urandom_range(0, 99) < key_pct);
        else if (w.command == CMD_LOOKUP && ring_count > 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
                w.seq = ring_seq[ring_slot($urandom_range(0, ring_count - 1))];
            else if (roll < 8)
                w.seq = oldest + $urandom_range(0, newest - oldest);
            else if (roll < 9)
                w.seq = oldest - $urandom_range(1, 50);
            else
                w.seq = newest + $urandom_range(1, 50);
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    // offers one word after a random gap and books the answer it owes once
    // the word is taken; a typed answer from the table replaces the mirror's
    task automatic send_word(input cache_cmd_t w, input bit typed,
                             input cache_result_t typed_answer);
        int            gap;
        cache_result_t owed;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= w.command;
        cmd_ch.seq_number   <= w.seq;
        cmd_ch.key_flag_in  <= w.key;
        cmd_ch.block_handle <= w.handle;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        owed = cache_apply(w);
        if (typed)
            owed = typed_answer;
        pending_answers.insert(pending_answers.size(), owed);
    endtask

    // one row of the directed table: command word, then the answer by hand
    task automatic add_row(input cmd_t c, input logic [SEQ_W-1:0] s, input logic k,
                           input logic [HANDLE_W-1:0] h, input status_t est,
                           input logic [HANDLE_W-1:0] eh, input logic [SEQ_W-1:0] es,
                           input logic ek, input logic [OCC_W-1:0] eocc);
        table_row_t row;
        row.word   = '{command: c, seq: s, key: k, handle: h};
        row.result = '{status: est, handle: eh, seq: es, key: ek, occ: eocc};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin
        phase_mode_t mode;
        int          phase_len;
        int          key_pct;
        int          sent;
        int          i;

        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_PUSH;
        cmd_ch.seq_number   <= '0;
        cmd_ch.key_flag_in  <= 1'b0;
        cmd_ch.block_handle <= '0;

        // empty store first: every read gives no data, clear and code 7 succeed
        add_row(CMD_LOOKUP,     32'd5, 1'b0, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_NEWEST,     32'd0, 1'b0, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_NEWEST_KEY, 32'd0, 1'b1, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_OLDEST,     32'd0, 1'b0, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_POP,        32'd0, 1'b0, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_CLEAR,      32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_UNUSED,     32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                ST_OK, 32'h0, 32'h0, 1'b0, 9'd0);
        // the extremes of the number, a zero handle, and stale pushes
        add_row(CMD_PUSH,       32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_PUSH,       32'd0, 1'b1, 32'h1, ST_ORDER,  32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_PUSH,       32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                ST_OK, 32'h0, 32'h0, 1'b0, 9'd2);
        add_row(CMD_PUSH,       32'hFFFFFFFF, 1'b0, 32'h5, ST_ORDER,
                32'h0, 32'h0, 1'b0, 9'd2);
        add_row(CMD_LOOKUP,     32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd2);
        add_row(CMD_LOOKUP,     32'hFFFFFFFF, 1'b0, 32'h0, ST_OK,
                32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 9'd2);
        // inside the range but not stored
        add_row(CMD_LOOKUP,     32'h80000000, 1'b0, 32'h0, ST_NODATA,
                32'h0, 32'h0, 1'b0, 9'd2);
        add_row(CMD_NEWEST_KEY, 32'd0, 1'b0, 32'h0, ST_OK,
                32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 9'd2);
        add_row(CMD_OLDEST,     32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd2);
        add_row(CMD_NEWEST,     32'd0, 1'b0, 32'h0, ST_OK,
                32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 9'd2);
        // pop hands back the removed entry
        add_row(CMD_POP,        32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_LOOKUP,     32'd0, 1'b0, 32'h0, ST_SMALL,  32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_CLEAR,      32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd0);
        add_row(CMD_PUSH,       32'd100, 1'b0, 32'hA5A5A5A5, ST_OK,
                32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_LOOKUP,     32'd101, 1'b0, 32'h0, ST_LARGE, 32'h0, 32'h0, 1'b0, 9'd1);
        // no key entry stored
        add_row(CMD_NEWEST_KEY, 32'd0, 1'b0, 32'h0, ST_NODATA, 32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_LOOKUP,     32'd99, 1'b0, 32'h0, ST_SMALL, 32'h0, 32'h0, 1'b0, 9'd1);
        add_row(CMD_UNUSED,     32'd0, 1'b0, 32'h0, ST_OK,     32'h0, 32'h0, 1'b0, 9'd1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].word, 1'b1, directed_rows[r].result);

        // random phases; the first one fills the ring far enough to hit full
        sent      = 0;
        mode      = MODE_FILL;
        phase_len = 420;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 2))
                0:       key_pct = 0;
                1:       key_pct = 10;
                default: key_pct = 50;
            endcase
            for (i = 0; i < phase_len && sent < RANDOM_WORDS; i++)
            begin
                send_word(random_word(mode, key_pct), 1'b0, '0);
                sent++;
            end
            mode      = phase_mode_t'($urandom_range(0, 2));
            phase_len = $urandom_range(60, 400);
        end
        cmd_ch.valid <= 1'b0;

        // drain what is owed, then leave room for a stray late word
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES + 8) @(posedge clk);

        if (bad_words == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // answer side
    // ------------------------------------------------------------------------
    initial
    begin
        int            gap;
        bit            held;
        cache_result_t got;
        cache_result_t owed;

        held         = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 14);
            // one long hold-off so that the block backs up onto the command side
            if (rsp_words == HOLD_AFTER && !held)
            begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);

            got.status = rsp_ch.status;
            got.handle = rsp_ch.handle_out;
            got.seq    = rsp_ch.seq_out;
            got.key    = rsp_ch.key_flag_out;
            got.occ    = rsp_ch.occupancy;
            rsp_words++;

            if (pending_answers.size() == 0)
            begin
                bad_words++;
                if (bad_words <= REPORT_MAX)
                    $display("answer word %0d with nothing owed: status %0d handle %h seq %h",
                             rsp_words, got.status, got.handle, got.seq);
            end
            else
            begin
                owed = pending_answers[0];
                pending_answers.delete(0);
                if (got.status !== owed.status || got.handle !== owed.handle ||
                    got.seq !== owed.seq || got.key !== owed.key || got.occ !== owed.occ)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                    begin
                        $display("answer word %0d mismatch", rsp_words);
                        $display("  expected status %0d handle %h seq %h key %0d occ %0d",
                                 owed.status, owed.handle, owed.seq, owed.key, owed.occ);
                        $display("  actual   status %0d handle %h seq %h key %0d occ %0d",
                                 got.status, got.handle, got.seq, got.key, got.occ);
                    end
                end
            end
        end
    end

endmodule
